// ===== hdl/u8fsd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8fsd_pkg
// Types, constants and the lead byte classifier shared by the decoder files.
// ----------------------------------------------------------------------------
package u8fsd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CntW  = 3;
  localparam int unsigned CpW   = 21;
  localparam int unsigned PayW  = 6;
  localparam int unsigned NumCont = 3;

  localparam logic [ByteW-1:0] ContLo  = 8'b1000_0000;
  localparam logic [ByteW-1:0] ContHi  = 8'b1011_1111;
  localparam logic [ByteW-1:0] E0Lo    = 8'hA0;
  localparam logic [ByteW-1:0] EdHi    = 8'h9F;
  localparam logic [ByteW-1:0] F0Lo    = 8'h90;
  localparam logic [ByteW-1:0] F4Hi    = 8'h8F;
  localparam logic [CpW-1:0]   CpRepl  = 21'h00FFFD;
  localparam logic [CntW-1:0]  MaxAvail = 3'd4;

  typedef struct packed {
    logic [CntW-1:0]  len;  // 0 invalid, 1 ASCII, 2..4 sequence length
    logic [ByteW-1:0] lo;   // allowed range of the second byte
    logic [ByteW-1:0] hi;
  } lead_class_t;

  // What one continuation lane reports back to the merge stage.
  typedef struct packed {
    logic            ok;
    logic [PayW-1:0] pay;
  } lane_res_t;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    logic [CntW-1:0] consumed_bytes;
  } result_t;

  function automatic lead_class_t classify_lead(input logic [ByteW-1:0] b);
    lead_class_t c;
    c.len = 3'd0;
    c.lo  = ContLo;
    c.hi  = ContHi;
    if (b inside {[8'h00:8'h7F]}) begin
      c.len = 3'd1;
    end else if (b inside {[8'hC2:8'hDF]}) begin
      c.len = 3'd2;
    end else if (b inside {[8'hE0:8'hEF]}) begin
      c.len = 3'd3;
      if (b == 8'hE0) c.lo = E0Lo;
      if (b == 8'hED) c.hi = EdHi;
    end else if (b inside {[8'hF0:8'hF4]}) begin
      c.len = 3'd4;
      if (b == 8'hF0) c.lo = F0Lo;
      if (b == 8'hF4) c.hi = F4Hi;
    end
    return c;
  endfunction

endpackage

// ===== hdl/u8fsd_if.sv =====
// ----------------------------------------------------------------------------
// u8fsd channel interfaces
// Valid/ready channels for the byte window and for the decoded symbol.
// ----------------------------------------------------------------------------
interface u8fsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] lead_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic [7:0] fourth_byte;
  logic [2:0] available_bytes;

  modport source (output valid, lead_byte, second_byte, third_byte, fourth_byte,
                  available_bytes, input ready);
  modport sink   (input valid, lead_byte, second_byte, third_byte, fourth_byte,
                  available_bytes, output ready);
endinterface

interface u8fsd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  consumed_bytes;

  modport source (output valid, code_point, consumed_bytes, input ready);
  modport sink   (input valid, code_point, consumed_bytes, output ready);
endinterface

// ===== hdl/u8fsd_lane.sv =====
// ----------------------------------------------------------------------------
// u8fsd_lane
// Checks one continuation byte against its allowed range and strips its
// payload bits.
// ----------------------------------------------------------------------------
module u8fsd_lane
  import u8fsd_pkg::*;
(
  input  logic [ByteW-1:0] byte_in,
  input  logic [ByteW-1:0] lo,
  input  logic [ByteW-1:0] hi,
  output lane_res_t        res
);

  assign res.ok  = (byte_in >= lo) && (byte_in <= hi);
  assign res.pay = byte_in[PayW-1:0];

endmodule

// ===== hdl/u8fsd_merge.sv =====
// ----------------------------------------------------------------------------
// u8fsd_merge
// Combines the lead class, the byte count and the lane reports into the
// decoded code point and its length.
// ----------------------------------------------------------------------------
module u8fsd_merge
  import u8fsd_pkg::*;
(
  input  logic [ByteW-1:0] lead,
  input  lead_class_t      cls,
  input  logic [CntW-1:0]  avail,
  input  lane_res_t        lane [NumCont],
  output result_t          res
);

  logic [CntW-1:0] avail_sat;

  assign avail_sat = (avail > MaxAvail) ? MaxAvail : avail;

  always_comb begin
    res.code_point     = CpRepl;
    res.consumed_bytes = 3'd1;
    if (avail_sat == 3'd0) begin
      res.code_point     = '0;
      res.consumed_bytes = 3'd0;
    end else if (cls.len == 3'd1) begin
      res.code_point = {13'd0, lead};
    end else if (cls.len >= 3'd2 && avail_sat >= cls.len && lane[0].ok) begin
      // Later lanes only count once the sequence is long enough to reach them.
      if (cls.len == 3'd2) begin
        res.code_point     = {10'd0, lead[4:0], lane[0].pay};
        res.consumed_bytes = 3'd2;
      end else if (lane[1].ok) begin
        if (cls.len == 3'd3) begin
          res.code_point     = {5'd0, lead[3:0], lane[0].pay, lane[1].pay};
          res.consumed_bytes = 3'd3;
        end else if (lane[2].ok) begin
          res.code_point     = {lead[2:0], lane[0].pay, lane[1].pay, lane[2].pay};
          res.consumed_bytes = 3'd4;
        end
      end
    end
  end

endmodule

// ===== hdl/utf8_first_symbol_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_first_symbol_decoder
// Decodes the first UTF-8 symbol of a window of up to four bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one window per item: four bytes and the count of valid
//   bytes (counts above four act as four). out_if returns one item per
//   window: the code point and the number of bytes it used, U+FFFD with
//   length 1 on any error, and zero with length 0 for an empty window.
//   Three continuation lanes check bytes two to four in parallel while the
//   lead byte is classified; a merge stage forms the result.
//   Each result is registered in the output queue on acceptance. Throughput
//   is one item per cycle while the queue has room, set by the single decode
//   stage feeding a two-entry output queue. When the receiver stalls the
//   queue fills with up to two results; in_if.ready drops only when both
//   entries are full and rises again in the cycle after one of them is
//   taken. A synchronous reset (rst_n low) empties the queue; no result is
//   shown until a new item is accepted.
// ----------------------------------------------------------------------------
module utf8_first_symbol_decoder
  import u8fsd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  u8fsd_in_if.sink    in_if,
  u8fsd_out_if.source out_if
);

  lead_class_t cls;
  lane_res_t   lane [NumCont];
  logic [ByteW-1:0] lane_byte [NumCont];
  logic [ByteW-1:0] lane_lo   [NumCont];
  logic [ByteW-1:0] lane_hi   [NumCont];
  result_t     dec;

  result_t     q_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push, pop;

  assign cls = classify_lead(in_if.lead_byte);

  assign lane_byte[0] = in_if.second_byte;
  assign lane_byte[1] = in_if.third_byte;
  assign lane_byte[2] = in_if.fourth_byte;
  // Only the second byte has a range that depends on the lead byte.
  assign lane_lo[0] = cls.lo;
  assign lane_hi[0] = cls.hi;
  assign lane_lo[1] = ContLo;
  assign lane_hi[1] = ContHi;
  assign lane_lo[2] = ContLo;
  assign lane_hi[2] = ContHi;

  for (genvar i = 0; i < NumCont; i++) begin : g_lane
    u8fsd_lane u_lane (
      .byte_in (lane_byte[i]),
      .lo      (lane_lo[i]),
      .hi      (lane_hi[i]),
      .res     (lane[i])
    );
  end

  u8fsd_merge u_merge (
    .lead  (in_if.lead_byte),
    .cls   (cls),
    .avail (in_if.available_bytes),
    .lane  (lane),
    .res   (dec)
  );

  assign in_if.ready = (cnt_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign out_if.valid = (cnt_r != 2'd0);
  assign pop         = out_if.valid && out_if.ready;

  assign out_if.code_point     = q_r[rd_ptr_r].code_point;
  assign out_if.consumed_bytes = q_r[rd_ptr_r].consumed_bytes;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== hdl/u8fsd_checker.sv =====
// ----------------------------------------------------------------------------
// u8fsd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module u8fsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic [2:0]  consumed_bytes
);

  // A stalled result keeps its value until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_point)
                                && $stable(consumed_bytes))
    else $error("stalled result changed");

  // Nothing is shown in the cycle after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // An empty window decodes to zero.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && consumed_bytes == 3'd0 |-> code_point == 21'd0)
    else $error("empty window with nonzero code point");

  // A one-byte result is either ASCII or the replacement symbol.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && consumed_bytes == 3'd1 |->
      code_point < 21'h80 || code_point == 21'h00FFFD)
    else $error("bad one-byte result");

endmodule

bind utf8_first_symbol_decoder u8fsd_checker u_u8fsd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .code_point     (out_if.code_point),
  .consumed_bytes (out_if.consumed_bytes)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for utf8_first_symbol_decoder. A directed list of byte
// windows covers the code point boundaries and the error forms. It is
// followed by random windows, most of them well-formed sequences and the
// rest broken or pure noise. Every accepted window is decoded here to an
// expected symbol, and each returned item is compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  import u8fsd_pkg::*;

  localparam int unsigned NumRandom = 1425;
  localparam int unsigned PhaseLen  = 483;

  typedef struct packed {
    logic [3:0][7:0] octet;        // octet[0] is the lead byte
    logic [2:0]      avail;
    logic            drain_first;  // hold off until all results are back
  } byte_window_t;

  logic clk;
  logic rst_n;

  u8fsd_in_if  in_if ();
  u8fsd_out_if out_if ();

  utf8_first_symbol_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  byte_window_t pending_windows[$];
  result_t      expected_symbols[$];
  int unsigned  n_accepted;
  int unsigned  fail_count;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Sequence length and allowed second byte range for a lead byte.
  function automatic void lead_range(input logic [7:0] b, output logic [2:0] n,
                                     output logic [7:0] lo, output logic [7:0] hi);
    n  = 3'd0;
    lo = ContLo;
    hi = ContHi;
    if (b <= 8'h7F) begin
      n = 3'd1;
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      n = 3'd2;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      n = 3'd3;
      // E0 would be overlong below A0, ED would reach the surrogates above 9F.
      if (b == 8'hE0) lo = E0Lo;
      if (b == 8'hED) hi = EdHi;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      n = 3'd4;
      if (b == 8'hF0) lo = F0Lo;
      if (b == 8'hF4) hi = F4Hi;
    end
  endfunction

  function automatic result_t decode_first_symbol(input byte_window_t w);
    result_t    r;
    logic [2:0] n;
    logic [2:0] seq_len;
    logic [7:0] lo;
    logic [7:0] hi;
    r.code_point     = CpRepl;
    r.consumed_bytes = 3'd1;
    n = (w.avail > MaxAvail) ? MaxAvail : w.avail;
    lead_range(w.octet[0], seq_len, lo, hi);
    if (n == 3'd0) begin
      r.code_point     = '0;
      r.consumed_bytes = '0;
    end else if (seq_len == 3'd1) begin
      r.code_point = {13'd0, w.octet[0]};
    end else if (seq_len >= 3'd2 && n >= seq_len &&
                 w.octet[1] >= lo && w.octet[1] <= hi) begin
      case (seq_len)
        3'd2: begin
          r.code_point     = {10'd0, w.octet[0][4:0], w.octet[1][5:0]};
          r.consumed_bytes = 3'd2;
        end
        3'd3: begin
          if (w.octet[2] inside {[ContLo:ContHi]}) begin
            r.code_point     = {5'd0, w.octet[0][3:0], w.octet[1][5:0],
                                w.octet[2][5:0]};
            r.consumed_bytes = 3'd3;
          end
        end
        default: begin
          if (w.octet[2] inside {[ContLo:ContHi]} &&
              w.octet[3] inside {[ContLo:ContHi]}) begin
            r.code_point     = {w.octet[0][2:0], w.octet[1][5:0], w.octet[2][5:0],
                                w.octet[3][5:0]};
            r.consumed_bytes = 3'd4;
          end
        end
      endcase
    end
    return r;
  endfunction

  // Idle percentage of either side in the current phase of the run.
  function automatic int unsigned idle_pct(input int unsigned n, input bit receiver);
    if (n < PhaseLen) return receiver ? 57 : 38;
    if (n < 2 * PhaseLen) return receiver ? 38 : 57;
    return 0;
  endfunction

  task automatic add_window(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2, input logic [7:0] b3,
                            input logic [2:0] avail, input logic drain);
    byte_window_t w;
    w.octet       = {b3, b2, b1, b0};
    w.avail       = avail;
    w.drain_first = drain;
    pending_windows.push_back(w);
  endtask

  task automatic note_failure(input string msg);
    if (fail_count < 10) $display("[%0t] %s", $realtime, msg);
    fail_count++;
  endtask

  // Driver: presents the oldest pending window and books its expected symbol
  // once it is taken.
  always @(posedge clk) begin : drive_windows
    logic offer;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      offer = in_if.valid;
      if (in_if.valid && in_if.ready) begin
        expected_symbols.push_back(decode_first_symbol(pending_windows.pop_front()));
        n_accepted <= n_accepted + 1;
        offer = 1'b0;
      end
      if (!offer && pending_windows.size() != 0 &&
          !(pending_windows[0].drain_first && expected_symbols.size() != 0) &&
          $urandom_range(99) >= idle_pct(n_accepted, 1'b0)) begin
        in_if.lead_byte       <= pending_windows[0].octet[0];
        in_if.second_byte     <= pending_windows[0].octet[1];
        in_if.third_byte      <= pending_windows[0].octet[2];
        in_if.fourth_byte     <= pending_windows[0].octet[3];
        in_if.available_bytes <= pending_windows[0].avail;
        offer = 1'b1;
      end
      in_if.valid <= offer;
    end
  end

  // Monitor: every symbol item must match the oldest expectation.
  always @(posedge clk) begin : check_symbols
    result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_symbols.size() == 0) begin
          note_failure($sformatf("unexpected item: code_point %06h consumed %0d",
                                 out_if.code_point, out_if.consumed_bytes));
        end else begin
          want = expected_symbols.pop_front();
          if (out_if.code_point !== want.code_point ||
              out_if.consumed_bytes !== want.consumed_bytes) begin
            note_failure($sformatf(
              "mismatch: code_point %06h consumed %0d, expected %06h consumed %0d",
              out_if.code_point, out_if.consumed_bytes,
              want.code_point, want.consumed_bytes));
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= idle_pct(n_accepted, 1'b1));
    end
  end

  initial begin : stimulus
    logic [3:0][7:0] oct;
    logic [2:0]      seq_len;
    logic [2:0]      avail;
    logic [7:0]      lo;
    logic [7:0]      hi;
    int unsigned     kind;
    int unsigned     k;

    rst_n                 = 1'b0;
    n_accepted            = 0;
    fail_count            = 0;
    in_if.valid           = 1'b0;
    in_if.lead_byte       = '0;
    in_if.second_byte     = '0;
    in_if.third_byte      = '0;
    in_if.fourth_byte     = '0;
    in_if.available_bytes = '0;
    out_if.ready          = 1'b0;

    // Empty window, then counts above four acting as four.
    add_window(8'h41, 8'h80, 8'h80, 8'h80, 3'd0, 1'b0);
    add_window(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd7, 1'b0);
    add_window(8'h7A, 8'hFF, 8'h00, 8'hFF, 3'd5, 1'b0);
    // ASCII extremes and invalid leads.
    add_window(8'h00, 8'h00, 8'h00, 8'h00, 3'd1, 1'b0);
    add_window(8'h7F, 8'hFF, 8'hFF, 8'hFF, 3'd4, 1'b0);
    add_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd4, 1'b0);
    add_window(8'hC1, 8'hBF, 8'h80, 8'h80, 3'd4, 1'b0);
    add_window(8'hF5, 8'h80, 8'h80, 8'h80, 3'd4, 1'b0);
    add_window(8'hFF, 8'hBF, 8'hBF, 8'hBF, 3'd4, 1'b0);
    // Two and three byte boundaries, overlong and surrogate forms.
    add_window(8'hC2, 8'h80, 8'h00, 8'h00, 3'd2, 1'b0);
    add_window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd4, 1'b0);
    add_window(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3, 1'b0);
    add_window(8'hE0, 8'h9F, 8'hBF, 8'h00, 3'd3, 1'b1);
    add_window(8'hED, 8'h9F, 8'hBF, 8'h00, 3'd3, 1'b0);
    add_window(8'hED, 8'hA0, 8'h80, 8'h00, 3'd4, 1'b0);
    add_window(8'hEF, 8'hBF, 8'hBF, 8'hBF, 3'd3, 1'b0);
    // Four byte boundaries, overlong and above the last code point.
    add_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd4, 1'b0);
    add_window(8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4, 1'b0);
    add_window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4, 1'b0);
    add_window(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4, 1'b0);
    // Truncated windows and bad later continuation bytes.
    add_window(8'hE2, 8'h82, 8'hAC, 8'h00, 3'd2, 1'b0);
    add_window(8'hF0, 8'h9F, 8'h98, 8'h80, 3'd3, 1'b0);
    add_window(8'hE2, 8'h82, 8'h2C, 8'h00, 3'd3, 1'b0);
    add_window(8'hF0, 8'h9F, 8'h98, 8'hC0, 3'd4, 1'b0);
    // Bytes past the symbol do not matter.
    add_window(8'hC3, 8'hA9, 8'hFF, 8'hFF, 3'd4, 1'b0);

    for (int unsigned i = 0; i < NumRandom; i++) begin
      kind = $urandom_range(99);
      if (kind < 20) begin
        oct   = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
        avail = 3'($urandom_range(7));
      end else begin
        seq_len = 3'($urandom_range(4, 1));
        case (seq_len)
          3'd1:    oct[0] = 8'($urandom_range(8'h7F));
          3'd2:    oct[0] = 8'($urandom_range(8'hDF, 8'hC2));
          3'd3:    oct[0] = 8'($urandom_range(8'hEF, 8'hE0));
          default: oct[0] = 8'($urandom_range(8'hF4, 8'hF0));
        endcase
        lead_range(oct[0], seq_len, lo, hi);
        oct[1] = 8'($urandom_range(hi, lo));
        oct[2] = 8'($urandom_range(ContHi, ContLo));
        oct[3] = 8'($urandom_range(ContHi, ContLo));
        for (int j = seq_len; j < 4; j++) oct[j] = 8'($urandom);
        avail = 3'($urandom_range(7, seq_len));
        // A share of the well-formed sequences gets broken on purpose.
        if (kind < 45) begin
          k = $urandom_range(3, 1);
          case ($urandom_range(2))
            0: avail = (seq_len > 3'd1) ? 3'($urandom_range(seq_len - 1)) : 3'd0;
            1: oct[k] = 8'($urandom);
            default: oct[k] = $urandom_range(1) ? 8'($urandom_range(8'h7F))
                                                : 8'($urandom_range(8'hFF, 8'hC0));
          endcase
        end
      end
      add_window(oct[0], oct[1], oct[2], oct[3], avail,
                 (i == PhaseLen) || (i == 2 * PhaseLen));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_windows.size() != 0 || expected_symbols.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);

    if (fail_count == 0) begin
      $display("** utf8_first_symbol_decoder: PASSED **");
    end else begin
      $display("** utf8_first_symbol_decoder: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("** utf8_first_symbol_decoder: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/u8fsd_pkg.sv
hdl/u8fsd_if.sv
hdl/u8fsd_lane.sv
hdl/u8fsd_merge.sv
hdl/utf8_first_symbol_decoder.sv
hdl/u8fsd_checker.sv
tb/tb_top.sv
